// ----- hdl/ceu_pkg.sv -----
`timescale 1ns / 1ps

package ceu_pkg;

    typedef enum logic [2:0] {
        MODE_IRQ       = 3'd0,
        MODE_TICK      = 3'd1,
        MODE_TRAP      = 3'd2,
        MODE_SYSCALL   = 3'd3,
        MODE_MSR_WRITE = 3'd4,
        MODE_DEC_WRITE = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        CAUSE_NONE    = 3'd0,
        CAUSE_IRQ     = 3'd1,
        CAUSE_DEC     = 3'd2,
        CAUSE_TRAP    = 3'd3,
        CAUSE_SYSCALL = 3'd4
    } cause_t;

    localparam logic [31:0] MSR_RESET      = 32'h0000_0040;
    localparam logic [31:0] MSR_CLEAR_MASK = 32'h0004_EF32;
    localparam logic [31:0] SAVE_MASK      = 32'h0000_FF73;
    localparam logic [31:0] TRAP_FLAG      = 32'h0002_0000;
    localparam logic [31:0] HIGH_VECTOR    = 32'hFFF0_0000;
    localparam logic [31:0] OFF_IRQ        = 32'h0000_0500;
    localparam logic [31:0] OFF_DEC        = 32'h0000_0900;
    localparam logic [31:0] OFF_TRAP       = 32'h0000_0700;
    localparam logic [31:0] OFF_SYSCALL    = 32'h0000_0C00;

    localparam int MSR_ILE_BIT = 16;
    localparam int MSR_EE_BIT  = 15;
    localparam int MSR_IP_BIT  = 6;
    localparam int MSR_LE_BIT  = 0;

    localparam int MODE_W     = 3;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 232;

    typedef struct packed {
        logic [31:0] write_value;
        logic        irq_level;
        logic [31:0] next_pc;
        logic [31:0] current_pc;
        logic [2:0]  mode;
    } in_item_t;

    typedef struct packed {
        logic [63:0] time_base_value;
        logic [31:0] decrementer_value;
        logic [31:0] status_word;
        logic [31:0] saved_status;
        logic [31:0] saved_pc;
        logic [2:0]  cause;
        logic [31:0] target_pc;
        logic        redirect;
    } result_t;

endpackage

// ----- hdl/ceu_in_reg.sv -----
`timescale 1ns / 1ps

module ceu_in_reg
    import ceu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    input  logic     advance,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // The register can take a new transaction when it is empty or is being drained.
    assign s_ready    = !valid_reg || advance;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- hdl/ceu_exec.sv -----
`timescale 1ns / 1ps

module ceu_exec
    import ceu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        advance,
    input  in_item_t    item,
    output result_t     result
);

    logic [31:0] vector_base_reg;
    logic [31:0] msr_reg, msr_next;
    logic [31:0] spc_reg, spc_next;
    logic [31:0] sst_reg, sst_next;
    logic [1:0]  pend_reg, pend_next;
    logic [31:0] dec_reg, dec_next;
    logic [63:0] tb_reg, tb_next;

    logic        take;
    logic [31:0] save_pc;
    logic [31:0] extra;
    logic [31:0] offset;
    cause_t      cause;
    logic [1:0]  pend_tick;
    logic [31:0] msr_entry;
    logic [31:0] target;

    // Status word after entry: standard bits cleared, LE follows ILE.
    always_comb
    begin
        msr_entry              = msr_reg & ~MSR_CLEAR_MASK;
        msr_entry[MSR_LE_BIT]  = msr_reg[MSR_ILE_BIT];
    end

    assign target = (msr_reg[MSR_IP_BIT] ? HIGH_VECTOR : vector_base_reg) | offset;

    always_comb
    begin
        take      = 1'b0;
        save_pc   = item.next_pc;
        extra     = '0;
        offset    = '0;
        cause     = CAUSE_NONE;
        pend_next = pend_reg;
        dec_next  = dec_reg;
        tb_next   = tb_reg;
        msr_next  = msr_reg;
        // A tick that brings the decrementer from one to zero pends its interrupt.
        pend_tick = pend_reg | {dec_reg == 32'd1, 1'b0};

        unique case (item.mode)
            MODE_IRQ:
            begin
                if (item.irq_level)
                begin
                    pend_next[0] = 1'b1;
                end
            end
            MODE_TICK:
            begin
                tb_next   = tb_reg + 64'd1;
                dec_next  = dec_reg - 32'd1;
                pend_next = pend_tick;
                if (msr_reg[MSR_EE_BIT])
                begin
                    priority if (pend_tick[0])
                    begin
                        take         = 1'b1;
                        offset       = OFF_IRQ;
                        cause        = CAUSE_IRQ;
                        pend_next[0] = 1'b0;
                    end
                    else if (pend_tick[1])
                    begin
                        take         = 1'b1;
                        offset       = OFF_DEC;
                        cause        = CAUSE_DEC;
                        pend_next[1] = 1'b0;
                    end
                    else
                    begin
                    end
                end
            end
            MODE_TRAP:
            begin
                take    = 1'b1;
                save_pc = item.current_pc;
                extra   = TRAP_FLAG;
                offset  = OFF_TRAP;
                cause   = CAUSE_TRAP;
            end
            MODE_SYSCALL:
            begin
                take   = 1'b1;
                offset = OFF_SYSCALL;
                cause  = CAUSE_SYSCALL;
            end
            MODE_MSR_WRITE:
            begin
                msr_next = item.write_value;
            end
            MODE_DEC_WRITE:
            begin
                dec_next = item.write_value;
            end
            default:
            begin
            end
        endcase

        spc_next = spc_reg;
        sst_next = sst_reg;
        if (take)
        begin
            spc_next = save_pc;
            sst_next = (msr_reg & SAVE_MASK) | extra;
            msr_next = msr_entry;
        end

        result.redirect          = take;
        result.target_pc         = take ? target : '0;
        result.cause             = cause;
        result.saved_pc          = spc_next;
        result.saved_status      = sst_next;
        result.status_word       = msr_next;
        result.decrementer_value = dec_next;
        result.time_base_value   = tb_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vector_base_reg <= '0;
            msr_reg         <= MSR_RESET;
            spc_reg         <= '0;
            sst_reg         <= '0;
            pend_reg        <= '0;
            dec_reg         <= '0;
            tb_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                vector_base_reg <= cfg_wdata;
            end
            if (advance)
            begin
                msr_reg  <= msr_next;
                spc_reg  <= spc_next;
                sst_reg  <= sst_next;
                pend_reg <= pend_next;
                dec_reg  <= dec_next;
                tb_reg   <= tb_next;
            end
        end
    end

endmodule

// ----- hdl/ceu_out_reg.sv -----
`timescale 1ns / 1ps

module ceu_out_reg
    import ceu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  result_t result,
    output logic    free,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign free       = !valid_reg || m_ready;
    assign valid_next = advance || (valid_reg && !m_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

// ----- hdl/cpu_exception_entry_unit_core.sv -----
`timescale 1ns / 1ps

// Exception-entry unit with decrementer and time base.
//
// Input channel (s_*): one transaction per event. s_tuser carries the event mode, s_tdata
// the PCs, the IRQ level and the write value. Output channel (m_*): one result
// transaction per input transaction, in order, with the redirect flag, vector address,
// cause and the architectural state after the event.
// cfg_we/cfg_wdata load the vector base register; write it only while no transaction
// is in flight.
//
// A transaction accepted into the input register passes to the output register, which raises m_tvalid.
// While the receiver keeps up, one transaction is accepted every cycle: the input
// register feeds a single pass of logic that updates the status, saved, pending,
// decrementer and time base registers and loads the output register in the same edge.
// When the receiver stalls, the output register holds its result and the input
// register still takes one more transaction before s_tready drops.
// Reset empties both registers, sets the status word to IP only and clears the saved
// registers, pending bits, decrementer, time base and vector base.

module cpu_exception_entry_unit_core
    import ceu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [31:0]           cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // mode
    input  logic [MODE_W-1:0]     s_tuser,
    // current_pc, next_pc, irq_level, write_value, zero fill
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // redirect, target_pc, cause, saved_pc, saved_status, status_word,
    // decrementer_value, time_base_value, zero fill
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int IN_USED  = $bits(in_item_t) - MODE_W;
    localparam int OUT_USED = $bits(result_t);

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     out_free;
    logic     advance;
    result_t  result;
    result_t  m_result;

    assign s_item = in_item_t'({s_tdata[IN_USED-1:0], s_tuser});

    assign advance = item_valid && out_free;

    ceu_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ceu_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .item      (item),
        .result    (result)
    );

    ceu_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .result   (result),
        .free     (out_free),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (m_result)
    );

    assign m_tdata = {{(OUT_DATA_W - OUT_USED){1'b0}}, m_result};

endmodule

// ----- hdl/ceu_checker.sv -----
`timescale 1ns / 1ps

module ceu_checker
    import ceu_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    logic        redirect;
    logic [31:0] target_pc;
    logic [2:0]  cause;
    logic [31:0] status_word;

    assign redirect    = m_tdata[0];
    assign target_pc   = m_tdata[32:1];
    assign cause       = m_tdata[35:33];
    assign status_word = m_tdata[131:100];

    // A result without an exception carries no vector and no cause.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !redirect |-> target_pc == 32'd0 && cause == CAUSE_NONE)
        else $error("result without redirect has vector or cause");

    // Every entry disables external interrupts in the new status word.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && redirect |-> !status_word[MSR_EE_BIT])
        else $error("exception entry left EE set");

    // The vector carries the offset bits of the reported cause; the base may add more.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && redirect |->
            (cause == CAUSE_IRQ &&
                (target_pc[11:0] & OFF_IRQ[11:0]) == OFF_IRQ[11:0]) ||
            (cause == CAUSE_DEC &&
                (target_pc[11:0] & OFF_DEC[11:0]) == OFF_DEC[11:0]) ||
            (cause == CAUSE_TRAP &&
                (target_pc[11:0] & OFF_TRAP[11:0]) == OFF_TRAP[11:0]) ||
            (cause == CAUSE_SYSCALL &&
                (target_pc[11:0] & OFF_SYSCALL[11:0]) == OFF_SYSCALL[11:0]))
        else $error("vector offset does not match cause");

    // A stalled result transaction holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // The input stalls only behind a full output register that the receiver holds off.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a stalled result");

endmodule

bind cpu_exception_entry_unit_core ceu_checker u_ceu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
